### rtl/core/cpf_pkg.sv
// Shared types, constants and the CRC byte update for the command packet framer.
package cpf_pkg;

  // Frame constants
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  SYNC_LO   = 8'h55;
  localparam logic [7:0]  SYNC_HI   = 8'h66;
  localparam logic [7:0]  CTRL_BYTE = 8'h01;
  localparam int unsigned HDR_LEN   = 8;
  localparam int unsigned NUM_CELLS = 11;   // header + data byte + two CRC bytes
  localparam int unsigned POS_W     = 4;    // holds 0..NUM_CELLS

  // What a byte slot carries when it reaches the head of the chain
  typedef enum logic [1:0] {
    SK_DATA,    // byte goes out as is and is folded into the CRC
    SK_CRC_LO,  // replaced by the low CRC byte
    SK_CRC_HI   // replaced by the high CRC byte, ends the packet
  } slot_kind_t;

  // One byte slot of the output chain
  typedef struct packed {
    logic       valid;
    slot_kind_t kind;
    logic       restart;     // first header byte: CRC starts over from zero
    logic [7:0] data;
    logic       run_end;
    logic       packet_end;
  } cpf_slot_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/command_packet_framer_crc16_core.sv
// Top level of the command packet framer: input hold stage, byte slot chain, CRC at the head.
//
//  channel | dir | tdata                                   | tuser               | tlast
//  in_     | in  | cmd_id[7:0] payload_len[23:8] data[31:24] | first[0] has_data[1] | last
//  out_    | out | out_byte[7:0]                           | packet_end          | run_end
//
// An accepted item is unpacked into up to 11 byte slots (one for its data byte, 8 more for
// a header, 2 more for the CRC) in a chain of cells that shifts one byte to the output
// per cycle while out_tready is high; the chain's single output port sets that rate.
// The CRC is folded in as each byte leaves the head. A one-item hold stage takes a new
// item while the chain is still draining.
// Reset (rst_n low, synchronous) clears CRC, sequence number, open flag and all valids.
// A stall on out_tready freezes the chain; the hold stage then fills and in_tready drops.
module command_packet_framer_crc16_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cmd_id[7:0], payload_len[23:8], data_byte[31:24]
  input  logic [1:0]  in_tuser,   // first[0], has_data[1]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte[7:0]
  output logic        out_tuser,  // packet_end[0]
  output logic        out_tlast
);
  import cpf_pkg::*;

  // Hold stage
  logic        hold_v_r, hold_v_nxt;
  logic        hold_first_r, hold_has_r, hold_last_r;
  logic [7:0]  hold_cmd_r, hold_data_r;
  logic [15:0] hold_len_r;

  // Packet state
  logic        open_r, open_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] crc_r, crc_nxt;

  // Chain
  cpf_slot_t   load_slot [NUM_CELLS];
  cpf_slot_t   cell_q    [NUM_CELLS];
  logic        chain_free, act, load_chain, head_fire, in_fire;
  logic        open_eff, has_eff, last_eff;
  logic [POS_W-1:0] hdr_len, crc_pos, n_bytes;
  cpf_slot_t   head;

  assign head       = cell_q[0];
  assign head_fire  = head.valid && out_tready;
  assign chain_free = !cell_q[1].valid && (!head.valid || out_tready);
  assign act        = hold_v_r && chain_free;
  assign in_tready  = !hold_v_r || chain_free;
  assign in_fire    = in_tvalid && in_tready;

  // Item decode
  assign open_eff   = hold_first_r || open_r;
  assign has_eff    = open_eff && hold_has_r;
  assign last_eff   = open_eff && hold_last_r;
  assign hdr_len    = hold_first_r ? POS_W'(HDR_LEN) : '0;
  assign crc_pos    = hdr_len + {{(POS_W-1){1'b0}}, has_eff};
  assign n_bytes    = crc_pos + (last_eff ? POS_W'(2) : '0);
  assign load_chain = act && (n_bytes != '0);

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx, input logic [15:0] len,
                                          input logic [15:0] seq, input logic [7:0] cmd);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = SYNC_LO;
      3'd1:    b = SYNC_HI;
      3'd2:    b = CTRL_BYTE;
      3'd3:    b = len[7:0];
      3'd4:    b = len[15:8];
      3'd5:    b = seq[7:0];
      3'd6:    b = seq[15:8];
      default: b = cmd;
    endcase
    return b;
  endfunction

  // Slot images of the held item, compacted from cell 0 up
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_build
    localparam logic [POS_W-1:0] POS = POS_W'(i);
    always_comb begin
      load_slot[i]            = '0;
      load_slot[i].valid      = POS < n_bytes;
      load_slot[i].run_end    = POS == (n_bytes - POS_W'(1));
      load_slot[i].kind       = SK_DATA;
      if (hold_first_r && (POS < POS_W'(HDR_LEN))) begin
        load_slot[i].data    = hdr_byte(POS[2:0], hold_len_r, seq_r, hold_cmd_r);
        load_slot[i].restart = (POS == '0);
      end else if (has_eff && (POS == hdr_len)) begin
        load_slot[i].data    = hold_data_r;
      end else if (last_eff && (POS == crc_pos)) begin
        load_slot[i].kind    = SK_CRC_LO;
      end else if (last_eff && (POS == crc_pos + POS_W'(1))) begin
        load_slot[i].kind       = SK_CRC_HI;
        load_slot[i].packet_end = 1'b1;
      end
    end
  end

  // Chain of byte cells, shifting toward the output
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cpf_slot_t nb;
    if (i == NUM_CELLS - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    cpf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .load      (load_chain),
      .load_slot (load_slot[i]),
      .shift     (head_fire),
      .next_slot (nb),
      .slot      (cell_q[i])
    );
  end

  // Hold stage next state
  assign hold_v_nxt = in_fire || (hold_v_r && !chain_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_first_r <= in_tuser[0];
      hold_has_r   <= in_tuser[1];
      hold_last_r  <= in_tlast;
      hold_cmd_r   <= in_tdata[7:0];
      hold_len_r   <= in_tdata[23:8];
      hold_data_r  <= in_tdata[31:24];
    end
  end

  // Packet open flag and sequence number, updated as items enter the chain
  always_comb begin
    open_nxt = open_r;
    seq_nxt  = seq_r;
    if (act) begin
      if (last_eff) begin
        open_nxt = 1'b0;
        seq_nxt  = seq_r + 16'd1;
      end else if (hold_first_r) begin
        open_nxt = 1'b1;
      end
    end
  end

  // Running CRC, updated as bytes leave the head
  always_comb begin
    crc_nxt = crc_r;
    if (head_fire) begin
      unique case (head.kind)
        SK_DATA:   crc_nxt = crc_feed(head.restart ? 16'h0000 : crc_r, head.data);
        SK_CRC_LO: crc_nxt = crc_r;
        SK_CRC_HI: crc_nxt = '0;
        default:   crc_nxt = crc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      seq_r  <= '0;
      crc_r  <= '0;
    end else begin
      open_r <= open_nxt;
      seq_r  <= seq_nxt;
      crc_r  <= crc_nxt;
    end
  end

  // Output side
  always_comb begin
    unique case (head.kind)
      SK_CRC_LO: out_tdata = crc_r[7:0];
      SK_CRC_HI: out_tdata = crc_r[15:8];
      default:   out_tdata = head.data;
    endcase
  end

  assign out_tvalid = head.valid;
  assign out_tlast  = head.run_end;
  assign out_tuser  = head.packet_end;

  // Slots stay compacted from the head
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    !cell_q[0].valid |-> !cell_q[1].valid)
    else $error("byte chain has a gap at the head");

  // The packet-ending byte is always the last of its item's run
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    head.valid && head.packet_end |-> head.run_end && (head.kind == SK_CRC_HI))
    else $error("packet end not on final CRC byte");

  // CRC clears once the high CRC byte is transferred
  a_crc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    head_fire && (head.kind == SK_CRC_HI) |=> crc_r == 16'h0000)
    else $error("CRC not cleared after packet end");

endmodule

### rtl/core/cpf_cell.sv
// One byte slot of the output chain: loads a new slot or takes its upstream neighbor's.
module cpf_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  cpf_pkg::cpf_slot_t load_slot,
  input  logic               shift,
  input  cpf_pkg::cpf_slot_t next_slot,
  output cpf_pkg::cpf_slot_t slot
);
  import cpf_pkg::*;

  cpf_slot_t slot_r;
  cpf_slot_t slot_nxt;

  // Load wins over shift; the chain is empty behind the head when loading
  always_comb begin
    priority if (load) begin
      slot_nxt = load_slot;
    end else if (shift) begin
      slot_nxt = next_slot;
    end else begin
      slot_nxt = slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot = slot_r;

endmodule
